// File: sv/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the page frame replacement core.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int FRAMES = 16;
    localparam int FIDX_W = $clog2(FRAMES);
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int PAGE_W = 10;
    localparam int CMD_W  = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index taken from paddr[2]
    localparam logic REG_POLICY = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RELEASE = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_DECIDE,
        S_ORD0_RD,
        S_ORD0_WAIT,
        S_CLOCK,
        S_EVICT_RD,
        S_EVICT_WAIT,
        S_INSTALL,
        S_REM_RD,
        S_REM_CMP,
        S_APPEND,
        S_FIN
    } t_state;

endpackage

// File: sv/page_frame_replacement_core.sv
// ----------------------------------------------------------------------------
// page_frame_replacement_core
// Fully associative frame table with LRU or enhanced clock replacement.
// ----------------------------------------------------------------------------
// Steps per beat: an unknown command goes straight to the result; the page lookup walks
//   the filled frames, an LRU update compacts the recency RAM entry by entry, and a
//   clock search steps one frame a cycle.
// Throughput: one beat at a time; the next input is taken the cycle after the result is
//   parked in the output register, which holds the core in its last state while stalled.
// Reset: synchronous, active low; clears flags, counters, hand and policy.
module page_frame_replacement_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [pfr_pkg::CMD_W-1:0]         i_command,
    input  logic [pfr_pkg::PAGE_W-1:0]        i_page_number,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [pfr_pkg::FIDX_W-1:0]        o_frame_index,
    output logic                              o_evicted_valid,
    output logic [pfr_pkg::PAGE_W-1:0]        o_evicted_page,
    output logic                              o_write_back,
    output logic                              o_released,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfr_pkg::APB_AW-1:0]        paddr,
    input  logic [pfr_pkg::APB_DW-1:0]        pwdata,
    output logic [pfr_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int F  = pfr_pkg::FRAMES;
    localparam int FW = pfr_pkg::FIDX_W;
    localparam int CW = pfr_pkg::CNT_W;
    localparam int PW = pfr_pkg::PAGE_W;

    // ------------------------------------------------------------------
    // Configuration: single policy register, written in the access phase
    // ------------------------------------------------------------------
    logic r_policy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == pfr_pkg::REG_POLICY)) begin
            r_policy <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pfr_pkg::REG_POLICY) ? {{(pfr_pkg::APB_DW-1){1'b0}}, r_policy}
                                                       : '0;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    pfr_pkg::t_state r_state, n_state;

    // per-frame flags live in flops; page numbers and recency order in RAM
    logic [F-1:0]  r_valid, n_valid;
    logic [F-1:0]  r_use,   n_use;
    logic [F-1:0]  r_mod,   n_mod;
    logic [CW-1:0] r_fill,  n_fill;
    logic [CW-1:0] r_len,   n_len;
    logic [FW-1:0] r_hand,  n_hand;

    // working registers for the beat in flight
    logic [pfr_pkg::CMD_W-1:0] r_cmd,  n_cmd;
    logic [PW-1:0]             r_page, n_page;
    logic [CW-1:0]             r_i,    n_i;
    logic [CW-1:0]             r_j,    n_j;
    logic [FW-1:0]             r_f,    n_f;
    logic                      r_found, n_found;
    logic                      r_fresh, n_fresh;
    logic                      r_append, n_append;
    logic                      r_phase, n_phase;
    logic [1:0]                r_round, n_round;
    logic [FW-1:0]             r_step,  n_step;

    // result being built
    logic          r_hit, n_hit;
    logic          r_ev,  n_ev;
    logic [PW-1:0] r_evp, n_evp;
    logic          r_wb,  n_wb;
    logic          r_rel, n_rel;

    // output register
    logic          r_ov;
    logic          r_o_hit, r_o_ev, r_o_wb, r_o_rel;
    logic [FW-1:0] r_o_fidx;
    logic [PW-1:0] r_o_evp;

    // RAM ports
    logic          pg_we;
    logic [FW-1:0] pg_raddr;
    logic [PW-1:0] pg_rdata;
    logic          od_we;
    logic [FW-1:0] od_waddr;
    logic [FW-1:0] od_wdata;
    logic [FW-1:0] od_raddr;
    logic [FW-1:0] od_rdata;

    pfr_ram #(.WIDTH(PW), .DEPTH(F)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (r_f),
        .i_wdata (r_page),
        .i_raddr (pg_raddr),
        .o_rdata (pg_rdata)
    );

    pfr_ram #(.WIDTH(FW), .DEPTH(F)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (od_we),
        .i_waddr (od_waddr),
        .i_wdata (od_wdata),
        .i_raddr (od_raddr),
        .o_rdata (od_rdata)
    );

    // ------------------------------------------------------------------
    // Highest released (invalid) frame, used once the table is full
    // ------------------------------------------------------------------
    logic          freed_any;
    logic [FW-1:0] freed_idx;

    always_comb begin
        freed_any = 1'b0;
        freed_idx = '0;
        for (int k = 0; k < F; k++) begin
            if (!r_valid[k]) begin
                freed_any = 1'b1;
                freed_idx = FW'(k);
            end
        end
    end

    // hand advance with wrap at the last frame
    logic [FW-1:0] hand_inc;
    assign hand_inc = (r_hand == FW'(F - 1)) ? '0 : r_hand + 1'b1;

    logic in_beat;
    logic out_load;
    logic look_match;
    logic is_write;

    assign in_beat    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == pfr_pkg::S_FIN) && (!r_ov || i_out_ready);
    assign look_match = r_valid[r_i[FW-1:0]] && (pg_rdata == r_page);
    assign is_write   = (r_cmd == pfr_pkg::CMD_WRITE);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pfr_pkg::S_IDLE: begin
                if (in_beat) begin
                    if (i_command == pfr_pkg::CMD_READ || i_command == pfr_pkg::CMD_WRITE ||
                        i_command == pfr_pkg::CMD_RELEASE) begin
                        n_state = pfr_pkg::S_LOOK_RD;
                    end else begin
                        n_state = pfr_pkg::S_FIN;
                    end
                end
            end
            pfr_pkg::S_LOOK_RD: begin
                n_state = (r_i == r_fill) ? pfr_pkg::S_DECIDE : pfr_pkg::S_LOOK_CMP;
            end
            pfr_pkg::S_LOOK_CMP: begin
                n_state = look_match ? pfr_pkg::S_DECIDE : pfr_pkg::S_LOOK_RD;
            end
            pfr_pkg::S_DECIDE: begin
                priority if (r_cmd == pfr_pkg::CMD_RELEASE) begin
                    n_state = r_found ? pfr_pkg::S_REM_RD : pfr_pkg::S_FIN;
                end else if (r_found) begin
                    n_state = r_policy ? pfr_pkg::S_FIN : pfr_pkg::S_REM_RD;
                end else if (r_fill != CW'(F) || freed_any) begin
                    n_state = pfr_pkg::S_INSTALL;
                end else if (r_policy) begin
                    n_state = pfr_pkg::S_CLOCK;
                end else if (r_len != '0) begin
                    n_state = pfr_pkg::S_ORD0_RD;
                end else begin
                    n_state = pfr_pkg::S_EVICT_RD;
                end
            end
            pfr_pkg::S_ORD0_RD:   n_state = pfr_pkg::S_ORD0_WAIT;
            pfr_pkg::S_ORD0_WAIT: n_state = pfr_pkg::S_EVICT_RD;
            pfr_pkg::S_CLOCK: begin
                if (!r_phase) begin
                    if (!r_use[r_hand] && !r_mod[r_hand]) n_state = pfr_pkg::S_EVICT_RD;
                end else begin
                    if (!r_use[r_hand]) begin
                        n_state = pfr_pkg::S_EVICT_RD;
                    end else if (r_step == FW'(F - 1) && r_round == 2'd3) begin
                        n_state = pfr_pkg::S_EVICT_RD;
                    end
                end
            end
            pfr_pkg::S_EVICT_RD:   n_state = pfr_pkg::S_EVICT_WAIT;
            pfr_pkg::S_EVICT_WAIT: n_state = pfr_pkg::S_INSTALL;
            pfr_pkg::S_INSTALL: begin
                n_state = r_policy ? pfr_pkg::S_FIN : pfr_pkg::S_REM_RD;
            end
            pfr_pkg::S_REM_RD: begin
                if (r_i == r_len) begin
                    n_state = r_append ? pfr_pkg::S_APPEND : pfr_pkg::S_FIN;
                end else begin
                    n_state = pfr_pkg::S_REM_CMP;
                end
            end
            pfr_pkg::S_REM_CMP: n_state = pfr_pkg::S_REM_RD;
            pfr_pkg::S_APPEND:  n_state = pfr_pkg::S_FIN;
            pfr_pkg::S_FIN: begin
                if (out_load) n_state = pfr_pkg::S_IDLE;
            end
            default: n_state = pfr_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and RAM controls
    // ------------------------------------------------------------------
    always_comb begin
        n_valid  = r_valid;
        n_use    = r_use;
        n_mod    = r_mod;
        n_fill   = r_fill;
        n_len    = r_len;
        n_hand   = r_hand;
        n_cmd    = r_cmd;
        n_page   = r_page;
        n_i      = r_i;
        n_j      = r_j;
        n_f      = r_f;
        n_found  = r_found;
        n_fresh  = r_fresh;
        n_append = r_append;
        n_phase  = r_phase;
        n_round  = r_round;
        n_step   = r_step;
        n_hit    = r_hit;
        n_ev     = r_ev;
        n_evp    = r_evp;
        n_wb     = r_wb;
        n_rel    = r_rel;
        pg_we    = 1'b0;
        pg_raddr = r_i[FW-1:0];
        od_we    = 1'b0;
        od_waddr = r_j[FW-1:0];
        od_wdata = od_rdata;
        od_raddr = r_i[FW-1:0];

        unique case (r_state)
            pfr_pkg::S_IDLE: begin
                if (in_beat) begin
                    // latch the beat and clear the result
                    n_cmd    = i_command;
                    n_page   = i_page_number;
                    n_i      = '0;
                    n_f      = '0;
                    n_found  = 1'b0;
                    n_fresh  = 1'b0;
                    n_append = 1'b0;
                    n_hit    = 1'b0;
                    n_ev     = 1'b0;
                    n_evp    = '0;
                    n_wb     = 1'b0;
                    n_rel    = 1'b0;
                end
            end
            pfr_pkg::S_LOOK_RD: begin
                pg_raddr = r_i[FW-1:0];
            end
            pfr_pkg::S_LOOK_CMP: begin
                if (look_match) begin
                    n_found = 1'b1;
                    n_f     = r_i[FW-1:0];
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            pfr_pkg::S_DECIDE: begin
                n_i     = '0;
                n_j     = '0;
                n_phase = 1'b0;
                n_round = '0;
                n_step  = '0;
                priority if (r_cmd == pfr_pkg::CMD_RELEASE) begin
                    if (r_found) begin
                        n_valid[r_f] = 1'b0;
                        n_use[r_f]   = 1'b0;
                        n_mod[r_f]   = 1'b0;
                        n_rel        = 1'b1;
                        n_append     = 1'b0;
                    end
                end else if (r_found) begin
                    n_hit    = 1'b1;
                    n_append = 1'b1;
                    if (r_policy) n_use[r_f] = 1'b1;
                    if (is_write) n_mod[r_f] = 1'b1;
                end else if (r_fill != CW'(F)) begin
                    // never-filled frame
                    n_f     = r_fill[FW-1:0];
                    n_fill  = r_fill + 1'b1;
                    n_fresh = 1'b1;
                end else if (freed_any) begin
                    n_f = freed_idx;
                end else if (!r_policy && r_len == '0) begin
                    n_f = '0;
                end
            end
            pfr_pkg::S_ORD0_RD: begin
                od_raddr = '0;
            end
            pfr_pkg::S_ORD0_WAIT: begin
                n_f = od_rdata;
            end
            pfr_pkg::S_CLOCK: begin
                // one frame a step: phase 0 wants use 0 and clean, phase 1 use 0
                n_f = r_hand;
                if (!r_phase) begin
                    if (r_use[r_hand] || r_mod[r_hand]) begin
                        n_hand = hand_inc;
                        n_step = r_step + 1'b1;
                        if (r_step == FW'(F - 1)) n_phase = 1'b1;
                    end
                end else begin
                    if (r_use[r_hand]) begin
                        n_use[r_hand] = 1'b0;
                        n_hand        = hand_inc;
                        n_step        = r_step + 1'b1;
                        n_f           = hand_inc;
                        if (r_step == FW'(F - 1)) begin
                            n_phase = 1'b0;
                            n_round = r_round + 1'b1;
                        end
                    end
                end
            end
            pfr_pkg::S_EVICT_RD: begin
                pg_raddr = r_f;
            end
            pfr_pkg::S_EVICT_WAIT: begin
                n_ev  = 1'b1;
                n_evp = pg_rdata;
                n_wb  = r_mod[r_f];
            end
            pfr_pkg::S_INSTALL: begin
                pg_we        = 1'b1;
                n_valid[r_f] = 1'b1;
                n_use[r_f]   = r_policy || !r_fresh;
                n_mod[r_f]   = is_write;
                n_append     = 1'b1;
                if (r_policy) n_hand = hand_inc;
            end
            pfr_pkg::S_REM_RD: begin
                od_raddr = r_i[FW-1:0];
                if (r_i == r_len) n_len = r_j;
            end
            pfr_pkg::S_REM_CMP: begin
                // compact in place: keep every entry other than this frame
                if (od_rdata != r_f) begin
                    od_we    = 1'b1;
                    od_waddr = r_j[FW-1:0];
                    od_wdata = od_rdata;
                    n_j      = r_j + 1'b1;
                end
                n_i = r_i + 1'b1;
            end
            pfr_pkg::S_APPEND: begin
                if (r_len != CW'(F)) begin
                    od_we    = 1'b1;
                    od_waddr = r_len[FW-1:0];
                    od_wdata = r_f;
                    n_len    = r_len + 1'b1;
                end
            end
            pfr_pkg::S_FIN: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfr_pkg::S_IDLE;
            r_valid <= '0;
            r_use   <= '0;
            r_mod   <= '0;
            r_fill  <= '0;
            r_len   <= '0;
            r_hand  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_use   <= n_use;
            r_mod   <= n_mod;
            r_fill  <= n_fill;
            r_len   <= n_len;
            r_hand  <= n_hand;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_page   <= n_page;
        r_i      <= n_i;
        r_j      <= n_j;
        r_f      <= n_f;
        r_found  <= n_found;
        r_fresh  <= n_fresh;
        r_append <= n_append;
        r_phase  <= n_phase;
        r_round  <= n_round;
        r_step   <= n_step;
        r_hit    <= n_hit;
        r_ev     <= n_ev;
        r_evp    <= n_evp;
        r_wb     <= n_wb;
        r_rel    <= n_rel;
        if (out_load) begin
            r_o_hit  <= r_hit;
            r_o_fidx <= r_f;
            r_o_ev   <= r_ev;
            r_o_evp  <= r_evp;
            r_o_wb   <= r_wb;
            r_o_rel  <= r_rel;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign o_in_ready      = (r_state == pfr_pkg::S_IDLE);
    assign o_out_valid     = r_ov;
    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_fidx;
    assign o_evicted_valid = r_o_ev;
    assign o_evicted_page  = r_o_evp;
    assign o_write_back    = r_o_wb;
    assign o_released      = r_o_rel;

endmodule

// File: sv/pfr_ram.sv
// ----------------------------------------------------------------------------
// pfr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/pfr_checker.sv
// ----------------------------------------------------------------------------
// pfr_checker
// Port-level checks on the result channel of the frame replacement core.
// ----------------------------------------------------------------------------
module pfr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_hit,
    input logic                       o_evicted_valid,
    input logic [pfr_pkg::PAGE_W-1:0] o_evicted_page,
    input logic                       o_write_back,
    input logic                       o_released
);

    // hold the beat until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped before acceptance");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted_valid))
        else $error("hit and eviction in one beat");

    a_wb_needs_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_write_back |-> o_evicted_valid)
        else $error("write-back without eviction");

    a_release_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_released |-> !o_hit && !o_evicted_valid)
        else $error("release beat carries access result");

    a_evict_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted_valid |-> o_evicted_page == '0)
        else $error("evicted page set without eviction");

endmodule

bind page_frame_replacement_core pfr_checker u_pfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page),
    .o_write_back    (o_write_back),
    .o_released      (o_released)
);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page frame replacement core: a queue-fed driver
// pushes access and release beats, a behavioural table predicts each result,
// and a monitor compares every output beat field by field. The run switches
// between LRU and enhanced clock policy over several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_QUIET = 20000;

    // command code outside the defined set, expected to be ignored
    localparam logic [pfr_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [pfr_pkg::CMD_W-1:0]  command;
        logic [pfr_pkg::PAGE_W-1:0] page;
    } t_access;

    typedef struct packed {
        logic                       hit;
        logic [pfr_pkg::FIDX_W-1:0] frame;
        logic                       ev_valid;
        logic [pfr_pkg::PAGE_W-1:0] ev_page;
        logic                       write_back;
        logic                       released;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [pfr_pkg::CMD_W-1:0] i_command = '0;
    logic [pfr_pkg::PAGE_W-1:0] i_page_number = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic o_hit, o_evicted_valid, o_write_back, o_released;
    logic [pfr_pkg::FIDX_W-1:0] o_frame_index;
    logic [pfr_pkg::PAGE_W-1:0] o_evicted_page;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [pfr_pkg::APB_AW-1:0] paddr = '0;
    logic [pfr_pkg::APB_DW-1:0] pwdata = '0;
    logic [pfr_pkg::APB_DW-1:0] prdata;
    logic pready;

    page_frame_replacement_core dut (.*);

    always #6 i_clk = ~i_clk;

    // predictor state for the frame table
    logic                       pol;
    logic [pfr_pkg::PAGE_W-1:0] tbl_page [pfr_pkg::FRAMES];
    logic                       tbl_valid [pfr_pkg::FRAMES];
    logic                       tbl_use [pfr_pkg::FRAMES];
    logic                       tbl_mod [pfr_pkg::FRAMES];
    int                         lru_list [$];
    int                         filled;
    int                         hand;

    t_access  pending_q [$];
    t_outcome expected_q [$];
    int       mismatches = 0;
    int       quiet = 0;
    int       send_gap = 0;
    int       recv_gap = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void advance_hand();
        hand = (hand + 1 >= pfr_pkg::FRAMES) ? 0 : hand + 1;
    endfunction

    function automatic void lru_drop(int f);
        for (int i = lru_list.size() - 1; i >= 0; i--)
            if (lru_list[i] == f) lru_list.delete(i);
    endfunction

    function automatic void lru_touch(int f);
        lru_drop(f);
        lru_list.push_back(f);
    endfunction

    function automatic int clock_pick();
        for (int r = 0; r < 4; r++) begin
            for (int i = 0; i < pfr_pkg::FRAMES; i++) begin
                if (!tbl_use[hand] && !tbl_mod[hand]) return hand;
                advance_hand();
            end
            for (int i = 0; i < pfr_pkg::FRAMES; i++) begin
                if (!tbl_use[hand]) return hand;
                tbl_use[hand] = 1'b0;
                advance_hand();
            end
        end
        return hand;
    endfunction

    function automatic int find_frame(logic [pfr_pkg::PAGE_W-1:0] pg);
        for (int i = 0; i < filled; i++)
            if (tbl_valid[i] && tbl_page[i] == pg) return i;
        return -1;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < pfr_pkg::FRAMES; i++) begin
            tbl_valid[i] = 1'b0; tbl_use[i] = 1'b0; tbl_mod[i] = 1'b0; tbl_page[i] = '0;
        end
        lru_list.delete();
        filled = 0; hand = 0; pol = 1'b0;
    endfunction

    // work out the outcome of one access or release
    function automatic t_outcome replace_predict(t_access a);
        t_outcome o;
        int f, freed;
        o = '0;
        if (a.command == pfr_pkg::CMD_RELEASE) begin
            f = find_frame(a.page);
            if (f >= 0) begin
                tbl_valid[f] = 1'b0; tbl_use[f] = 1'b0; tbl_mod[f] = 1'b0;
                lru_drop(f);
                o.released = 1'b1; o.frame = f[pfr_pkg::FIDX_W-1:0];
            end
        end else if (a.command == pfr_pkg::CMD_READ || a.command == pfr_pkg::CMD_WRITE) begin
            f = find_frame(a.page);
            if (f >= 0) begin
                o.hit = 1'b1;
            end else if (filled < pfr_pkg::FRAMES) begin
                f = filled++;
                tbl_page[f] = a.page; tbl_valid[f] = 1'b1;
                tbl_use[f] = pol; tbl_mod[f] = 1'b0;
                if (pol) advance_hand(); else lru_touch(f);
            end else begin
                freed = -1;
                for (int i = 0; i < pfr_pkg::FRAMES; i++) if (!tbl_valid[i]) freed = i;
                if (freed >= 0) begin
                    f = freed;
                end else begin
                    if (pol) f = clock_pick();
                    else if (lru_list.size() > 0) f = lru_list[0];
                    else f = 0;
                    o.ev_valid = 1'b1; o.ev_page = tbl_page[f]; o.write_back = tbl_mod[f];
                end
                tbl_page[f] = a.page; tbl_valid[f] = 1'b1;
                tbl_use[f] = 1'b1; tbl_mod[f] = 1'b0;
                if (pol) advance_hand(); else lru_touch(f);
            end
            if (pol) tbl_use[f] = 1'b1; else lru_touch(f);
            if (a.command == pfr_pkg::CMD_WRITE) tbl_mod[f] = 1'b1;
            o.frame = f[pfr_pkg::FIDX_W-1:0];
        end
        return o;
    endfunction

    // driver: present the next beat and hold it until it is taken
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(replace_predict({i_command, i_page_number}));
                send_gap = gap_len();
                if (send_gap == 0 && pending_q.size() > 0) begin
                    {i_command, i_page_number} <= pending_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid) begin
                if (send_gap > 0) send_gap--;
                else if (pending_q.size() > 0) begin
                    {i_command, i_page_number} <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end
            end
        end
    end

    // monitor: check each output beat and stall the receiver now and then
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_hit, o_frame_index, o_evicted_valid, o_evicted_page,
                       o_write_back, o_released};
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
                    end
                end
                recv_gap = gap_len();
                i_out_ready <= (recv_gap == 0);
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= (recv_gap == 0);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog: count cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= MAX_QUIET) begin
            $display("FAIL page_frame_replacement_core");
            $finish;
        end
    end

    task automatic write_policy(logic v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {pfr_pkg::REG_POLICY, 2'b00}; pwdata <= {31'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pol = v;
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && !i_in_valid && expected_q.size() == 0);
        repeat (100) @(posedge i_clk);
    endtask

    function automatic logic [pfr_pkg::PAGE_W-1:0] pick_page(int span);
        if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
        return 10'($urandom_range(0, span - 1) * 37 + 5);
    endfunction

    task automatic random_phase(int n, int span);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45)      pending_q.push_back({pfr_pkg::CMD_READ, pick_page(span)});
            else if (r < 80) pending_q.push_back({pfr_pkg::CMD_WRITE, pick_page(span)});
            else if (r < 97) pending_q.push_back({pfr_pkg::CMD_RELEASE, pick_page(span)});
            else             pending_q.push_back({CMD_UNUSED, pick_page(span)});
        end
    endtask

    initial begin
        clear_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: fill, hit, release hit and miss, unknown command, evict
        pending_q.push_back({pfr_pkg::CMD_READ, 10'd0});
        pending_q.push_back({pfr_pkg::CMD_WRITE, 10'd1023});
        pending_q.push_back({pfr_pkg::CMD_READ, 10'd0});
        pending_q.push_back({pfr_pkg::CMD_RELEASE, 10'd555});
        pending_q.push_back({CMD_UNUSED, 10'h2AA});
        pending_q.push_back({CMD_UNUSED, 10'h155});
        for (int i = 0; i < 15; i++) pending_q.push_back({pfr_pkg::CMD_WRITE, 10'(100 + i)});
        pending_q.push_back({pfr_pkg::CMD_READ, 10'd700});
        pending_q.push_back({pfr_pkg::CMD_RELEASE, 10'd1023});
        pending_q.push_back({pfr_pkg::CMD_READ, 10'd701});
        pending_q.push_back({pfr_pkg::CMD_READ, 10'd702});
        drain();
        // clock mode on a full table, then back and forth
        write_policy(1'b1);
        random_phase(200, 24);
        drain();
        write_policy(1'b0);
        random_phase(200, 28);
        drain();
        write_policy(1'b1);
        random_phase(250, 40);
        drain();
        write_policy(1'b0);
        random_phase(220, 20);
        drain();
        if (mismatches == 0) $display("PASS page_frame_replacement_core");
        else $display("FAIL page_frame_replacement_core");
        $finish;
    end

endmodule
